// ===== hdl/lmc4_pkg.sv =====
package lmc4_pkg;

	localparam int MaxColumns = 128;
	localparam int MaxRows    = 128;

	localparam int ColW    = $clog2(MaxColumns);
	localparam int RowW    = $clog2(MaxRows);
	localparam int SizeW   = 8;
	localparam int SampleW = 16;
	localparam int CountW  = 15;
	localparam int CfgIdxW = 2;

	localparam logic [CountW-1:0] CountLimit = {CountW{1'b1}};

	localparam logic [CfgIdxW-1:0] RegRowCount    = CfgIdxW'(0);
	localparam logic [CfgIdxW-1:0] RegColumnCount = CfgIdxW'(1);

	typedef logic signed [SampleW-1:0] sample_t;
	typedef logic [CountW-1:0]         count_t;

	// line buffer entry: value and its beaten flag
	typedef struct packed {
		sample_t value;
		logic    beaten;
	} line_entry_t;

	function automatic logic [ColW:0] clamp_cols(input logic [SizeW-1:0] v);
		logic [ColW:0] r;
		if (v == '0) begin
			r = (ColW+1)'(1);
		end else if (32'(v) > 32'(MaxColumns)) begin
			r = (ColW+1)'(MaxColumns);
		end else begin
			r = (ColW+1)'(v);
		end
		return r;
	endfunction

	function automatic logic [RowW:0] clamp_rows(input logic [SizeW-1:0] v);
		logic [RowW:0] r;
		if (v == '0) begin
			r = (RowW+1)'(1);
		end else if (32'(v) > 32'(MaxRows)) begin
			r = (RowW+1)'(MaxRows);
		end else begin
			r = (RowW+1)'(v);
		end
		return r;
	endfunction

endpackage

// ===== hdl/lmc4_if.sv =====
interface lmc4_sample_if import lmc4_pkg::*; ();
	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

interface lmc4_count_if import lmc4_pkg::*; ();
	logic   valid;
	logic   ready;
	count_t maxima_count;

	modport source (output valid, output maxima_count, input ready);
	modport sink (input valid, input maxima_count, output ready);
endinterface

// ===== hdl/local_maxima_count_4_neighbor.sv =====
// Counts 4-neighbour local maxima over a matrix of signed Q8.8 samples streamed in raster
// order, one sample word per clock. Frame size comes from row_count (index 0) and
// column_count (index 1); zero acts as 1 and values above 128 act as 128. Writing either
// register abandons the frame in progress. Each sample is registered together with a read
// of the 128-entry line buffer that holds the row above, and is then resolved against
// that entry (the tail register for the last column) and the left register. The frame's
// last sample is registered into stage s1, and when it resolves the count word is loaded
// into the output register. Samples are taken every clock; input ready drops only when a
// frame ends while the previous count word is still waiting at the output.
module local_maxima_count_4_neighbor import lmc4_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	lmc4_sample_if.sink        samples,
	lmc4_count_if.source       counts,
	input  logic               cfg_wr_en,
	input  logic [CfgIdxW-1:0] cfg_index,
	input  logic [SizeW-1:0]   cfg_data
);

	logic [SizeW-1:0] rows_q, cols_q;
	logic [RowW:0]    rows_eff;
	logic [ColW:0]    cols_eff;
	logic [RowW-1:0]  row_q;
	logic [ColW-1:0]  col_q;
	logic             cfg_hit, accept, last_row_in, last_col_in;

	logic             s1_valid_q;
	sample_t          sample_s1;
	logic [ColW-1:0]  col_s1;
	logic             top_row_s1, last_row_s1, last_col_s1;
	line_entry_t      above_s1;
	logic             s1_final, s1_go;

	line_entry_t      line_mem [MaxColumns];
	line_entry_t      tail_q;
	sample_t          left_q;
	logic             left_beaten_q;
	count_t           count_q;
	logic             out_valid_q;
	count_t           out_count_q;

	line_entry_t      above;
	logic             beaten, left_beat, b_above, b_left, b_self;
	logic             wr_en;
	logic [ColW-1:0]  wr_addr;
	line_entry_t      wr_data;
	logic [1:0]       bumps;
	logic [CountW:0]  sum;
	count_t           count_next;

	assign rows_eff = clamp_rows(rows_q);
	assign cols_eff = clamp_cols(cols_q);
	assign cfg_hit  = cfg_wr_en && (cfg_index == RegRowCount || cfg_index == RegColumnCount);
	assign accept   = samples.valid && samples.ready;

	assign last_row_in = ({1'b0, row_q} + (RowW+1)'(1)) == rows_eff;
	assign last_col_in = ({1'b0, col_q} + (ColW+1)'(1)) == cols_eff;

	assign s1_final      = last_row_s1 && last_col_s1;
	assign s1_go         = s1_valid_q && (!s1_final || !out_valid_q || counts.ready);
	assign samples.ready = !s1_valid_q || s1_go;

	// last column of the row above lives in the tail register
	always_comb begin
		above     = last_col_s1 ? tail_q : above_s1;
		left_beat = left_beaten_q || (sample_s1 > left_q);
		beaten    = (!top_row_s1 && (above.value > sample_s1)) ||
		            ((col_s1 != '0) && (left_q > sample_s1));
		b_above   = !top_row_s1 && !(above.beaten || (sample_s1 > above.value));
		b_left    = (col_s1 != '0) && last_row_s1 && !left_beat;
		b_self    = s1_final && !beaten;
		bumps     = 2'({1'b0, b_above}) + 2'({1'b0, b_left}) + 2'({1'b0, b_self});
		sum       = {1'b0, count_q} + (CountW+1)'(bumps);
		count_next = (sum > (CountW+1)'(CountLimit)) ? CountLimit : sum[CountW-1:0];
	end

	assign wr_en        = s1_go && (col_s1 != '0) && !last_row_s1;
	assign wr_addr      = col_s1 - ColW'(1);
	assign wr_data      = '{value: left_q, beaten: left_beat};

	// config registers and input position
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= SizeW'(1);
			cols_q <= SizeW'(1);
			row_q  <= '0;
			col_q  <= '0;
		end else if (cfg_hit) begin
			if (cfg_index == RegRowCount) begin
				rows_q <= cfg_data;
			end else begin
				cols_q <= cfg_data;
			end
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			if (last_col_in) begin
				col_q <= '0;
				row_q <= last_row_in ? '0 : row_q + RowW'(1);
			end else begin
				col_q <= col_q + ColW'(1);
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (samples.ready) begin
			s1_valid_q <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			sample_s1   <= samples.sample;
			col_s1      <= col_q;
			top_row_s1  <= (row_q == '0);
			last_row_s1 <= last_row_in;
			last_col_s1 <= last_col_in;
		end
	end

	// line buffer, write forwarded to a read of the same entry
	always_ff @(posedge clk) begin
		if (wr_en) begin
			line_mem[wr_addr] <= wr_data;
		end
		if (accept) begin
			above_s1 <= (wr_en && wr_addr == col_q) ? wr_data : line_mem[col_q];
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_col_s1 && !last_row_s1) begin
			tail_q <= '{value: sample_s1, beaten: beaten};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			left_q        <= '0;
			left_beaten_q <= 1'b0;
			count_q       <= '0;
		end else if (cfg_hit) begin
			left_q        <= '0;
			left_beaten_q <= 1'b0;
			count_q       <= '0;
		end else if (s1_go) begin
			left_q        <= sample_s1;
			left_beaten_q <= beaten;
			count_q       <= s1_final ? '0 : count_next;
		end
	end

	// output word register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s1_go && s1_final) begin
			out_valid_q <= 1'b1;
		end else if (counts.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && s1_final) begin
			out_count_q <= count_next;
		end
	end

	assign counts.valid        = out_valid_q;
	assign counts.maxima_count = out_count_q;

	a_final_gives_word: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && s1_final |=> counts.valid)
		else $error("frame end did not load the count word");

	a_write_in_row: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |-> ({1'b0, wr_addr} + (ColW+1)'(1)) < cols_eff)
		else $error("line buffer write past the row");

	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		!samples.ready |-> s1_valid_q && s1_final && counts.valid && !counts.ready)
		else $error("input stalled without a waiting count word");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		s1_valid_q && top_row_s1 |-> !b_above)
		else $error("top row sample credited an element above");

endmodule
